>>> design/ipsl_pkg.sv
`timescale 1ns / 1ps

package ipsl_pkg;

  // field and register widths
  localparam int DATA_W    = 16;
  localparam int ALPHA_W   = 9;
  localparam int CFG_IDX_W = 3;
  localparam int ERR_W     = DATA_W + 1;

  // bit-serial multiplier: signed multiplicands, unsigned multipliers
  localparam int MCAND_W   = ERR_W + 1;
  localparam int MPLR_W    = 16;
  localparam int ACC_HI_W  = MCAND_W + 2;
  localparam int PROD_W    = ACC_HI_W + MPLR_W;
  localparam int STEP_W    = $clog2(MPLR_W);

  // low-pass filter accumulator: 256*avg + alpha*(prev - avg)
  localparam int FILT_ACC_W = 26;
  localparam int FILT_SHIFT = 8;

  // alpha of one in Q8
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  // register reset values
  localparam logic [DATA_W-1:0]  PROP_GAIN_RST     = 16'd2816;
  localparam logic [DATA_W-1:0]  INTEGRAL_GAIN_RST = 16'd90;
  localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST  = 9'd179;
  localparam logic [DATA_W-1:0]  DRIVE_MAX_RST     = 16'd7200;
  localparam logic [DATA_W-1:0]  DRIVE_MIN_RST     = 16'd4200;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_FILTER_ALPHA  = 3'd2,
    REG_DRIVE_MAX     = 3'd3,
    REG_DRIVE_MIN     = 3'd4
  } cfg_idx_t;

  // register set as seen by the datapath, alpha already saturated
  typedef struct packed {
    logic [DATA_W-1:0]  prop_gain;
    logic [DATA_W-1:0]  integral_gain;
    logic [ALPHA_W-1:0] alpha;
    logic [DATA_W-1:0]  drive_max;
    logic [DATA_W-1:0]  drive_min;
  } cfg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_FMUL,
    ST_FILT,
    ST_ERR,
    ST_PMUL,
    ST_INC,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

>>> design/ipsl_cfg.sv
`timescale 1ns / 1ps

module ipsl_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ipsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ipsl_pkg::DATA_W-1:0]       cfg_data,
  output ipsl_pkg::cfg_t                    cfg
);

  logic [ipsl_pkg::DATA_W-1:0]  prop_gain;
  logic [ipsl_pkg::DATA_W-1:0]  integral_gain;
  logic [ipsl_pkg::ALPHA_W-1:0] alpha_raw;
  logic [ipsl_pkg::DATA_W-1:0]  drive_max;
  logic [ipsl_pkg::DATA_W-1:0]  drive_min;

  // register file, writes outside the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= ipsl_pkg::PROP_GAIN_RST;
      integral_gain <= ipsl_pkg::INTEGRAL_GAIN_RST;
      alpha_raw     <= ipsl_pkg::FILTER_ALPHA_RST;
      drive_max     <= ipsl_pkg::DRIVE_MAX_RST;
      drive_min     <= ipsl_pkg::DRIVE_MIN_RST;
    end else if (cfg_we) begin
      case (ipsl_pkg::cfg_idx_t'(cfg_index))
        ipsl_pkg::REG_PROP_GAIN:     prop_gain     <= cfg_data;
        ipsl_pkg::REG_INTEGRAL_GAIN: integral_gain <= cfg_data;
        ipsl_pkg::REG_FILTER_ALPHA:  alpha_raw     <= cfg_data[ipsl_pkg::ALPHA_W-1:0];
        ipsl_pkg::REG_DRIVE_MAX:     drive_max     <= cfg_data;
        ipsl_pkg::REG_DRIVE_MIN:     drive_min     <= cfg_data;
        default: ;
      endcase
    end
  end

  // alpha above one acts as one
  always_comb begin
    cfg.prop_gain     = prop_gain;
    cfg.integral_gain = integral_gain;
    cfg.alpha         = (alpha_raw > ipsl_pkg::ALPHA_ONE) ? ipsl_pkg::ALPHA_ONE : alpha_raw;
    cfg.drive_max     = drive_max;
    cfg.drive_min     = drive_min;
  end

endmodule

>>> design/ipsl_mac.sv
`timescale 1ns / 1ps

// Bit-serial multiply-add: prod = x*a + y*b, one multiplier bit per cycle,
// LSB first. The partial sum is shifted right, so the adder stays narrow.
module ipsl_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic signed [ipsl_pkg::MCAND_W-1:0]  x,
  input  logic signed [ipsl_pkg::MCAND_W-1:0]  y,
  input  logic [ipsl_pkg::MPLR_W-1:0]          a,
  input  logic [ipsl_pkg::MPLR_W-1:0]          b,
  output logic                                 done,
  output logic signed [ipsl_pkg::PROD_W-1:0]   prod
);

  localparam int HI_W = ipsl_pkg::ACC_HI_W;
  localparam int MC_W = ipsl_pkg::MCAND_W;
  localparam int ML_W = ipsl_pkg::MPLR_W;
  localparam logic [ipsl_pkg::STEP_W-1:0] STEP_LAST = ipsl_pkg::STEP_W'(ML_W - 1);

  logic                          run;
  logic [ipsl_pkg::STEP_W-1:0]   cnt;
  logic signed [MC_W-1:0]        x_r;
  logic signed [MC_W-1:0]        y_r;
  logic [ML_W-1:0]               a_r;
  logic [ML_W-1:0]               b_r;
  logic signed [HI_W-1:0]        hi;
  logic [ML_W-1:0]               lo;

  logic signed [HI_W-1:0]        addend;
  logic signed [HI_W:0]          step_sum;

  // one step: add selected multiplicands into the upper half
  always_comb begin
    addend   = ({{(HI_W-MC_W){x_r[MC_W-1]}}, x_r} & {HI_W{a_r[0]}})
             + ({{(HI_W-MC_W){y_r[MC_W-1]}}, y_r} & {HI_W{b_r[0]}});
    step_sum = {hi[HI_W-1], hi} + {addend[HI_W-1], addend};
  end

  assign done = run && (cnt == STEP_LAST);
  assign prod = {hi, lo};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (load) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 1'b1;
      if (done) begin
        run <= 1'b0;
      end
    end
  end

  // operand and partial-sum shift registers
  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= x;
      y_r <= y;
      a_r <= a;
      b_r <= b;
      hi  <= '0;
      lo  <= '0;
    end else if (run) begin
      hi  <= step_sum[HI_W:1];
      lo  <= {step_sum[0], lo[ML_W-1:1]};
      a_r <= {1'b0, a_r[ML_W-1:1]};
      b_r <= {1'b0, b_r[ML_W-1:1]};
    end
  end

endmodule

>>> design/incremental_pi_speed_loop.sv
`timescale 1ns / 1ps

// channel | signals                                        | direction
// --------+------------------------------------------------+----------
// in      | in_valid, in_ready, count_b, count_a,          | in
//         | target_speed, clear                            |
// out     | out_valid, out_ready, drive, filtered_speed    | out
// cfg     | cfg_we, cfg_index, cfg_data                    | in
//
// A word passes from acceptance through two 16-step passes of the bit-serial
// multiplier (filter weight, then PI gains) and the sequencing states to its
// result in the output register. A cleared word goes straight to the done state.
// One word is in work at a time; the next is accepted while a result waits.
// Reset (rst, synchronous) restores the register defaults and zeroes history.
// A stalled output holds the sequencer before it overwrites the result.
module incremental_pi_speed_loop #(
  parameter int GAIN_FRACTION_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ipsl_pkg::DATA_W-1:0]  count_b,
  input  logic signed [ipsl_pkg::DATA_W-1:0]  count_a,
  input  logic signed [ipsl_pkg::DATA_W-1:0]  target_speed,
  input  logic                                clear,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ipsl_pkg::DATA_W-1:0]         drive,
  output logic signed [ipsl_pkg::DATA_W-1:0]  filtered_speed,
  input  logic                                cfg_we,
  input  logic [ipsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipsl_pkg::DATA_W-1:0]         cfg_data
);

  localparam int DW     = ipsl_pkg::DATA_W;
  localparam int EW     = ipsl_pkg::ERR_W;
  localparam int MCW    = ipsl_pkg::MCAND_W;
  localparam int PW     = ipsl_pkg::PROD_W;
  localparam int FAW    = ipsl_pkg::FILT_ACC_W;
  localparam int FSH    = ipsl_pkg::FILT_SHIFT;
  localparam int INC_W  = PW - GAIN_FRACTION_BITS;
  localparam int SUM_W  = INC_W + 1;
  localparam logic [PW-1:0]  FRAC_MASK = PW'((64'd1 << GAIN_FRACTION_BITS) - 64'd1);
  localparam logic [FAW-1:0] FILT_MASK = FAW'((1 << FSH) - 1);

  ipsl_pkg::cfg_t    cfg;
  ipsl_pkg::state_t  st;
  ipsl_pkg::state_t  st_next;

  // control and history state
  logic signed [DW-1:0]  spd_hist;
  logic signed [EW-1:0]  ehist;
  logic [DW-1:0]         total;

  // working registers
  logic signed [DW-1:0]    cb_r;
  logic signed [DW-1:0]    ca_r;
  logic signed [DW-1:0]    tgt_r;
  logic signed [DW-1:0]    avg_r;
  logic signed [DW-1:0]    filt_r;
  logic signed [INC_W-1:0] inc_r;
  logic [DW-1:0]           res_drive;

  // multiplier hookup
  logic                          mac_load;
  logic signed [MCW-1:0]         mac_x;
  logic signed [MCW-1:0]         mac_y;
  logic [ipsl_pkg::MPLR_W-1:0]   mac_a;
  logic [ipsl_pkg::MPLR_W-1:0]   mac_b;
  logic                          mac_done;
  logic signed [PW-1:0]          prod;

  logic in_acc;
  logic out_load;

  // datapath combinational terms
  logic signed [DW:0]      pair_sum;
  logic signed [DW:0]      pair_adj;
  logic signed [DW-1:0]    avg_c;
  logic signed [DW:0]      dlt_c;
  logic signed [FAW-1:0]   facc;
  logic signed [FAW-1:0]   fadj;
  logic signed [DW-1:0]    filt_c;
  logic signed [EW-1:0]    err_c;
  logic signed [MCW-1:0]   de_c;
  logic signed [PW-1:0]    num_adj;
  logic signed [INC_W-1:0] inc_c;
  logic signed [SUM_W-1:0] sum_c;
  logic signed [SUM_W-1:0] max_s;
  logic signed [SUM_W-1:0] min_s;
  logic signed [SUM_W-1:0] hi_clamp;
  logic signed [SUM_W-1:0] clamp_c;

  ipsl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipsl_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .load (mac_load),
    .x    (mac_x),
    .y    (mac_y),
    .a    (mac_a),
    .b    (mac_b),
    .done (mac_done),
    .prod (prod)
  );

  // average of the two counts, truncated toward zero
  always_comb begin
    pair_sum = {cb_r[DW-1], cb_r} + {ca_r[DW-1], ca_r};
    pair_adj = pair_sum + {{DW{1'b0}}, pair_sum[DW]};
    avg_c    = pair_adj[DW:1];
    dlt_c    = {spd_hist[DW-1], spd_hist} - {avg_c[DW-1], avg_c};
  end

  // filter: (256*avg + alpha*(prev - avg)) / 256, truncated toward zero
  always_comb begin
    facc   = prod[FAW-1:0] + {{(FAW-DW-FSH){avg_r[DW-1]}}, avg_r, {FSH{1'b0}}};
    fadj   = facc + (facc[FAW-1] ? FILT_MASK : '0);
    filt_c = fadj[DW+FSH-1:FSH];
  end

  // speed error and its change
  always_comb begin
    err_c = {tgt_r[DW-1], tgt_r} - {filt_r[DW-1], filt_r};
    de_c  = {err_c[EW-1], err_c} - {ehist[EW-1], ehist};
  end

  // PI increment, truncated toward zero
  always_comb begin
    num_adj = prod + (prod[PW-1] ? FRAC_MASK : '0);
    inc_c   = num_adj[PW-1:GAIN_FRACTION_BITS];
  end

  // accumulate and clamp: maximum first, then minimum
  always_comb begin
    sum_c    = $signed({{(SUM_W-DW){1'b0}}, total}) + $signed({inc_r[INC_W-1], inc_r});
    max_s    = $signed({{(SUM_W-DW){1'b0}}, cfg.drive_max});
    min_s    = $signed({{(SUM_W-DW){1'b0}}, cfg.drive_min});
    hi_clamp = (sum_c > max_s) ? max_s : sum_c;
    clamp_c  = (hi_clamp < min_s) ? min_s : hi_clamp;
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ipsl_pkg::ST_IDLE: begin
        if (in_valid) begin
          st_next = clear ? ipsl_pkg::ST_DONE : ipsl_pkg::ST_AVG;
        end
      end
      ipsl_pkg::ST_AVG:  st_next = ipsl_pkg::ST_FMUL;
      ipsl_pkg::ST_FMUL: begin
        if (mac_done) begin
          st_next = ipsl_pkg::ST_FILT;
        end
      end
      ipsl_pkg::ST_FILT: st_next = ipsl_pkg::ST_ERR;
      ipsl_pkg::ST_ERR:  st_next = ipsl_pkg::ST_PMUL;
      ipsl_pkg::ST_PMUL: begin
        if (mac_done) begin
          st_next = ipsl_pkg::ST_INC;
        end
      end
      ipsl_pkg::ST_INC:  st_next = ipsl_pkg::ST_SUM;
      ipsl_pkg::ST_SUM:  st_next = ipsl_pkg::ST_DONE;
      ipsl_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          st_next = ipsl_pkg::ST_IDLE;
        end
      end
      default: st_next = ipsl_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    mac_load = 1'b0;
    out_load = 1'b0;
    mac_x    = de_c;
    mac_y    = {err_c[EW-1], err_c};
    mac_a    = cfg.prop_gain;
    mac_b    = cfg.integral_gain;
    case (st)
      ipsl_pkg::ST_IDLE: in_ready = 1'b1;
      ipsl_pkg::ST_AVG: begin
        mac_load = 1'b1;
        mac_x    = {dlt_c[DW], dlt_c};
        mac_y    = '0;
        mac_a    = {{(ipsl_pkg::MPLR_W-ipsl_pkg::ALPHA_W){1'b0}}, cfg.alpha};
        mac_b    = '0;
      end
      ipsl_pkg::ST_ERR:  mac_load = 1'b1;
      ipsl_pkg::ST_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign in_acc = in_valid && in_ready;

  // sequencer, history and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ipsl_pkg::ST_IDLE;
      out_valid <= 1'b0;
      spd_hist  <= '0;
      ehist     <= '0;
      total     <= '0;
    end else begin
      st <= st_next;
      if (in_acc && clear) begin
        spd_hist <= '0;
        ehist    <= '0;
        total    <= '0;
      end
      if (st == ipsl_pkg::ST_FILT) begin
        spd_hist <= filt_c;
      end
      if (st == ipsl_pkg::ST_ERR) begin
        ehist <= err_c;
      end
      if (st == ipsl_pkg::ST_SUM) begin
        total <= clamp_c[DW-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cb_r  <= count_b;
      ca_r  <= count_a;
      tgt_r <= target_speed;
      if (clear) begin
        filt_r    <= '0;
        res_drive <= '0;
      end
    end
    if (st == ipsl_pkg::ST_AVG) begin
      avg_r <= avg_c;
    end
    if (st == ipsl_pkg::ST_FILT) begin
      filt_r <= filt_c;
    end
    if (st == ipsl_pkg::ST_INC) begin
      inc_r <= inc_c;
    end
    if (st == ipsl_pkg::ST_SUM) begin
      res_drive <= clamp_c[DW-1:0];
    end
    if (out_load) begin
      drive          <= res_drive;
      filtered_speed <= filt_r;
    end
  end

endmodule

>>> design/ipsl_check.sv
`timescale 1ns / 1ps

module ipsl_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [ipsl_pkg::DATA_W-1:0]  count_b,
  input  logic signed [ipsl_pkg::DATA_W-1:0]  count_a,
  input  logic signed [ipsl_pkg::DATA_W-1:0]  target_speed,
  input  logic                                clear,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [ipsl_pkg::DATA_W-1:0]         drive,
  input  logic signed [ipsl_pkg::DATA_W-1:0]  filtered_speed,
  input  logic                                cfg_we,
  input  logic [ipsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipsl_pkg::DATA_W-1:0]         cfg_data
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // one word in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input accepted while a word is in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(drive) && $stable(filtered_speed)))
    else $error("stalled result changed");

  // no result without a word behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pend != 2'd0))
    else $error("result with no word pending");

  // at most one word in work plus one held result
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("too many words pending");

  // a clear word with a free output gives a zero result from the done state
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (in_acc && clear && !out_valid) |=> ##1
      (out_valid && (drive == '0) && (filtered_speed == '0)))
    else $error("clear did not give a zero result");

  // configuration port is write-only; keep its inputs referenced
  logic unused_ok;
  assign unused_ok = ^{count_b, count_a, target_speed, cfg_we, cfg_index, cfg_data};

endmodule

bind incremental_pi_speed_loop ipsl_check u_check (.*);

>>> verif/tb_incremental_pi_speed_loop.sv
`timescale 1ns / 1ps

// expected result of one control tick
typedef struct {
  logic [15:0]        drive;
  logic signed [15:0] speed;
} tick_result_t;

// Predicts each tick of the speed loop and checks the block's results in order.
class pi_loop_scoreboard;
  localparam int GAIN_FRAC = 8;

  bit [15:0] prop_gain;
  bit [15:0] integral_gain;
  bit [8:0]  filter_alpha;
  bit [15:0] drive_max;
  bit [15:0] drive_min;

  logic signed [15:0] speed_prev;
  logic signed [17:0] error_prev;
  longint             drive_acc;

  tick_result_t expected_q[$];
  int errors;
  int checked;

  function new();
    prop_gain     = ipsl_pkg::PROP_GAIN_RST;
    integral_gain = ipsl_pkg::INTEGRAL_GAIN_RST;
    filter_alpha  = ipsl_pkg::FILTER_ALPHA_RST;
    drive_max     = ipsl_pkg::DRIVE_MAX_RST;
    drive_min     = ipsl_pkg::DRIVE_MIN_RST;
    speed_prev    = '0;
    error_prev    = '0;
    drive_acc     = 0;
    errors        = 0;
    checked       = 0;
  endfunction

  // register write; unknown indexes are ignored
  function void write_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      ipsl_pkg::REG_PROP_GAIN:     prop_gain     = data;
      ipsl_pkg::REG_INTEGRAL_GAIN: integral_gain = data;
      ipsl_pkg::REG_FILTER_ALPHA:  filter_alpha  = data[8:0];
      ipsl_pkg::REG_DRIVE_MAX:     drive_max     = data;
      ipsl_pkg::REG_DRIVE_MIN:     drive_min     = data;
      default: ;
    endcase
  endfunction

  // accepted input word: advance the loop state and queue the expected result
  function void note_word(logic signed [15:0] cnt_b, logic signed [15:0] cnt_a,
                          logic signed [15:0] target, logic clr);
    tick_result_t res;
    longint avg, alpha, filt, err, num, inc, total;
    if (clr) begin
      speed_prev = '0;
      error_prev = '0;
      drive_acc  = 0;
      res.drive  = '0;
      res.speed  = '0;
      expected_q.push_back(res);
      return;
    end
    // average truncates toward zero
    avg   = (longint'(cnt_b) + longint'(cnt_a)) / 2;
    alpha = (filter_alpha > 9'd256) ? 256 : longint'(filter_alpha);
    filt  = (alpha * longint'(speed_prev) + (256 - alpha) * avg) / 256;
    speed_prev = filt[15:0];

    // incremental PI step
    err = longint'(target) - filt;
    num = longint'(prop_gain) * (err - longint'(error_prev))
        + longint'(integral_gain) * err;
    inc = num / (longint'(1) << GAIN_FRAC);
    error_prev = err[17:0];

    // max clamp first, min clamp wins
    total = drive_acc + inc;
    if (total > longint'(drive_max)) total = longint'(drive_max);
    if (total < longint'(drive_min)) total = longint'(drive_min);
    drive_acc = total;

    res.drive = total[15:0];
    res.speed = filt[15:0];
    expected_q.push_back(res);
  endfunction

  function void check_word(logic [15:0] drv, logic signed [15:0] spd);
    tick_result_t want;
    if (expected_q.size() == 0) begin
      $error("result with none expected: drive %0d filtered_speed %0d", drv, spd);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (drv !== want.drive) begin
      $error("drive mismatch: expected %0d, got %0d", want.drive, drv);
      errors++;
    end
    if (spd !== want.speed) begin
      $error("filtered_speed mismatch: expected %0d, got %0d", want.speed, spd);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_incremental_pi_speed_loop;
  localparam int GAIN_FRAC   = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 45;
  // index past the register list, must be ignored
  localparam logic [2:0] REG_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic signed [15:0]  count_b      = '0;
  logic signed [15:0]  count_a      = '0;
  logic signed [15:0]  target_speed = '0;
  logic                clear        = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [15:0]         drive;
  logic signed [15:0]  filtered_speed;
  logic                cfg_we       = 1'b0;
  logic [2:0]          cfg_index    = '0;
  logic [15:0]         cfg_data     = '0;

  pi_loop_scoreboard sb;
  int cycles = 0;
  int words_sent;
  int clears_sent;
  int settings_used;
  bit tx_fast;
  bit rx_fast = 1'b0;
  int cruise;

  incremental_pi_speed_loop #(
    .GAIN_FRACTION_BITS(GAIN_FRAC)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .count_b        (count_b),
    .count_a        (count_a),
    .target_speed   (target_speed),
    .clear          (clear),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive          (drive),
    .filtered_speed (filtered_speed),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result check at the accepting edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_word(drive, filtered_speed);
    end
  end

  // receiver: random stall before each word, with stall-free stretches
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 24) == 0) rx_fast = !rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one input word, held until accepted
  task automatic send_word(logic signed [15:0] cb, logic signed [15:0] ca,
                           logic signed [15:0] tgt, logic clr);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_fast = !tx_fast;
    gap = tx_fast ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    count_b      <= cb;
    count_a      <= ca;
    target_speed <= tgt;
    clear        <= clr;
    do @(posedge clk); while (!in_ready);
    sb.note_word(cb, ca, tgt, clr);
    words_sent++;
    if (clr) clears_sent++;
  endtask

  // hold off until every expected result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic write_all(logic [15:0] pg, logic [15:0] ig, logic [15:0] alpha,
                           logic [15:0] dmax, logic [15:0] dmin);
    write_reg(ipsl_pkg::REG_PROP_GAIN, pg);
    write_reg(ipsl_pkg::REG_INTEGRAL_GAIN, ig);
    write_reg(ipsl_pkg::REG_FILTER_ALPHA, alpha);
    write_reg(ipsl_pkg::REG_DRIVE_MAX, dmax);
    write_reg(ipsl_pkg::REG_DRIVE_MIN, dmin);
    settings_used++;
  endtask

  // mostly closed-loop ticks near a cruising target, some clears, some noise
  task automatic run_random(int n);
    int kind;
    logic signed [15:0] cb, ca, tgt;
    logic clr;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) cruise = int'($urandom_range(0, 600)) - 300;
      kind = $urandom_range(0, 99);
      clr  = 1'b0;
      if (kind < 6) begin
        clr = 1'b1;
        cb  = 16'($urandom);
        ca  = 16'($urandom);
        tgt = 16'($urandom);
      end else if (kind < 70) begin
        tgt = 16'(cruise);
        cb  = 16'(cruise + int'($urandom_range(0, 80)) - 40);
        ca  = 16'(cruise + int'($urandom_range(0, 80)) - 40);
      end else begin
        cb  = 16'($urandom);
        ca  = 16'($urandom);
        tgt = 16'($urandom);
      end
      send_word(cb, ca, tgt, clr);
      // sender pause until the pipeline is empty
      if (i % 64 == 63) wait_drained();
    end
  endtask

  initial begin
    sb = new();
    words_sent = 0;
    clears_sent = 0;
    settings_used = 1;
    tx_fast = 1'b0;
    cruise = 150;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed ticks at the reset settings
    send_word(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
    send_word(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_word(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_word(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    // odd sums: average truncates toward zero
    send_word(16'sd32767, -16'sd32768, 16'sd0, 1'b0);
    send_word(-16'sd3, 16'sd0, 16'sd100, 1'b0);
    send_word(16'sd3, 16'sd0, -16'sd100, 1'b0);
    // largest errors push the drive into both clamps
    send_word(-16'sd32768, -16'sd32768, 16'sd32767, 1'b0);
    send_word(-16'sd32768, -16'sd32768, 16'sd32767, 1'b0);
    send_word(16'sd32767, 16'sd32767, -16'sd32768, 1'b0);
    send_word(16'sd32767, 16'sd32767, -16'sd32768, 1'b0);
    send_word(16'sd0, 16'sd0, 16'sd0, 1'b1);
    // short settling run toward a target
    send_word(16'sd150, 16'sd160, 16'sd200, 1'b0);
    send_word(16'sd180, 16'sd190, 16'sd200, 1'b0);
    send_word(16'sd200, 16'sd210, 16'sd200, 1'b0);
    send_word(16'sd220, 16'sd215, 16'sd200, 1'b0);
    send_word(-16'sd1, -16'sd2, -16'sd200, 1'b0);
    send_word(16'sd0, 16'sd0, 16'sd0, 1'b1);
    run_random(70);
    wait_drained();

    // extremes: full gains, no filtering, widest clamp range
    write_all(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'h0000);
    send_word(-16'sd32768, -16'sd32768, 16'sd32767, 1'b0);
    send_word(16'sd32767, 16'sd32767, -16'sd32768, 1'b0);
    run_random(60);
    wait_drained();

    // zero gains, alpha of one, zero-width clamp
    write_all(16'd0, 16'd0, 16'd256, 16'd0, 16'd0);
    run_random(40);
    wait_drained();

    // alpha above one saturates; min above max
    write_all(16'($urandom), 16'($urandom_range(0, 1023)), 16'd511, 16'd1000, 16'd5000);
    send_word(16'sd1000, 16'sd1000, 16'sd0, 1'b0);
    run_random(60);
    wait_drained();

    // spare index ignored; alpha upper data bits dropped
    write_all(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 511)), 16'hFE80,
              16'd9000, 16'd1000);
    write_reg(REG_SPARE, 16'hFFFF);
    run_random(60);
    wait_drained();

    // random settings
    for (int p = 0; p < 2; p++) begin
      write_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 511)),
                16'($urandom), 16'($urandom));
      run_random(50);
      wait_drained();
    end

    repeat (TAIL) @(posedge clk);
    $display("Covered %0d words (%0d clears) under %0d register settings,",
             words_sent, clears_sent, settings_used);
    $display("%0d results compared, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
